### src/crht_pkg.sv
// shared types and constants for the circle/rectangle hit test
`timescale 1ns / 1ps
package crht_pkg;
  // per-edge operands after setup; sized for COORD_BITS up to 32
  localparam int unsigned VW = 36;  // coordinate differences
  localparam int unsigned SW = 64;  // squares of magnitudes clamped to 32 bits
  typedef struct packed {
    logic        en;   // nonzero length
    logic [VW-1:0] d;  // |offset|
    logic signed [VW-1:0] lo;  // segment start minus center
    logic signed [VW-1:0] hi;  // segment end minus center
  } edge_t;
endpackage

### src/crht_edge.sv
// three-stage per-edge crossing test
`timescale 1ns / 1ps
module crht_edge (
  input  logic                clk,
  input  crht_pkg::edge_t     edge_in,
  input  logic [crht_pkg::VW-1:0] radius,
  output logic                hit
);
  localparam int unsigned VW = crht_pkg::VW;
  localparam int unsigned SW = crht_pkg::SW;

  // radius stays below 2^31; d only matters when it is below the radius
  logic [31:0] r32, d32;
  always_comb begin
    r32 = radius[31:0];
    d32 = edge_in.d[31:0];
  end

  // stage 1: squares of radius and distance, bounds registered
  logic          ok1_r;
  logic [SW-1:0] rem_a_r, rem_b_r;
  logic signed [VW-1:0] lo1_r, hi1_r;
  always_ff @(posedge clk) begin
    ok1_r   <= edge_in.en && (edge_in.d < radius);
    rem_a_r <= SW'(r32) * SW'(r32);
    rem_b_r <= SW'(d32) * SW'(d32);
    lo1_r   <= edge_in.lo;
    hi1_r   <= edge_in.hi;
  end

  // stage 2: remainder and bound squares
  // magnitudes of 2^32 and up saturate; their squares still exceed any remainder
  logic          ok2_r;
  logic [SW-1:0] rem2_r, lo_sq_r, hi_sq_r;
  logic          hi_neg_r, lo_pos_r, hi_pos_r;
  logic [VW-1:0] lo_mag, hi_mag;
  logic [31:0]   lo_cl, hi_cl;
  always_comb begin
    lo_mag = lo1_r[VW-1] ? VW'(-lo1_r) : VW'(lo1_r);
    hi_mag = hi1_r[VW-1] ? VW'(-hi1_r) : VW'(hi1_r);
    lo_cl  = (|lo_mag[VW-1:32]) ? '1 : lo_mag[31:0];
    hi_cl  = (|hi_mag[VW-1:32]) ? '1 : hi_mag[31:0];
  end
  always_ff @(posedge clk) begin
    ok2_r    <= ok1_r;
    rem2_r   <= rem_a_r - rem_b_r;
    lo_sq_r  <= SW'(lo_cl) * SW'(lo_cl);
    hi_sq_r  <= SW'(hi_cl) * SW'(hi_cl);
    hi_neg_r <= hi1_r[VW-1];
    lo_pos_r <= !lo1_r[VW-1] && (lo1_r != '0);
    hi_pos_r <= !hi1_r[VW-1] && (hi1_r != '0);
  end

  // stage 3: either crossing point on the segment
  logic ge_lo, le_hi, le_nlo, ge_nhi;
  logic hit_r;
  always_comb begin
    ge_lo  = !lo_pos_r || (lo_sq_r <= rem2_r);  // s >= lo
    le_hi  = !hi_neg_r && (rem2_r <= hi_sq_r);  // s <= hi
    le_nlo = !lo_pos_r && (rem2_r <= lo_sq_r);  // s <= -lo
    ge_nhi = hi_pos_r || (hi_sq_r <= rem2_r);   // s >= -hi
  end
  always_ff @(posedge clk) begin
    hit_r <= ok2_r && ((ge_lo && le_hi) || (le_nlo && ge_nhi));
  end
  assign hit = hit_r;
endmodule

### src/circle_rectangle_hit_test.sv
// circle versus rectangle edge hit test, top level
// results pass through the request register, the offset stage and the edge-test stages to out_valid
// throughput: one request per cycle, busy is always low
// reset: synchronous active-low rst_n clears the valid pipeline
// the receiver cannot stall; out_valid is a one-cycle strobe
`timescale 1ns / 1ps
module circle_rectangle_hit_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [COORD_BITS-2:0]        in_circle_radius,
  input  logic signed [COORD_BITS-1:0] in_corner_x,
  input  logic signed [COORD_BITS-1:0] in_corner_y,
  input  logic [COORD_BITS-2:0]        in_rect_width,
  input  logic [COORD_BITS-2:0]        in_rect_height,
  output logic                         out_valid,
  output logic                         out_hit
);
  localparam int unsigned VW = crht_pkg::VW;

  assign busy = 1'b0;

  // stage 0: register the request
  logic [4:0] vld_r;
  logic signed [VW-1:0] cx_r, cy_r, kx_r, ky_r, w_r, h_r;
  logic [VW-1:0] r_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end
  always_ff @(posedge clk) begin
    cx_r <= VW'(in_center_x);
    cy_r <= VW'(in_center_y);
    kx_r <= VW'(in_corner_x);
    ky_r <= VW'(in_corner_y);
    w_r  <= VW'({1'b0, in_rect_width});
    h_r  <= VW'({1'b0, in_rect_height});
    r_r  <= VW'(in_circle_radius);
  end

  // stage 1: per-edge offsets and bounds
  crht_pkg::edge_t el_r, et_r, eb_r;
  logic [VW-1:0] r1_r;
  logic signed [VW-1:0] xl, ol, ot, ob;
  always_comb begin
    xl = kx_r - w_r;
    ol = xl - cx_r;
    ot = ky_r + h_r - cy_r;
    ob = ky_r - cy_r;
  end
  always_ff @(posedge clk) begin
    r1_r     <= r_r;
    el_r.en  <= h_r != '0;
    el_r.d   <= ol[VW-1] ? VW'(-ol) : VW'(ol);
    el_r.lo  <= ky_r - cy_r;
    el_r.hi  <= ky_r + h_r - cy_r;
    et_r.en  <= w_r != '0;
    et_r.d   <= ot[VW-1] ? VW'(-ot) : VW'(ot);
    et_r.lo  <= xl - cx_r;
    et_r.hi  <= kx_r - cx_r;
    eb_r.en  <= w_r != '0;
    eb_r.d   <= ob[VW-1] ? VW'(-ob) : VW'(ob);
    eb_r.lo  <= xl - cx_r;
    eb_r.hi  <= kx_r - cx_r;
  end

  // stages 2-4: edge tests
  logic hl, ht, hb;
  crht_edge u_left   (.clk(clk), .edge_in(el_r), .radius(r1_r), .hit(hl));
  crht_edge u_top    (.clk(clk), .edge_in(et_r), .radius(r1_r), .hit(ht));
  crht_edge u_bottom (.clk(clk), .edge_in(eb_r), .radius(r1_r), .hit(hb));

  assign out_valid = vld_r[4];
  assign out_hit   = hl | ht | hb;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start ##5 1 |-> out_valid || !rst_n) else $error("result lost");
  a_zero_r: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_circle_radius == '0) |-> ##5 !out_hit) else $error("zero radius hit");
`endif
endmodule

### test/circle_rectangle_hit_test_tb.sv
// testbench for the circle/rectangle edge hit test: directed table plus random requests
`timescale 1ns / 1ps
module circle_rectangle_hit_test_tb;
  localparam int CB = 24;
  localparam int LATENCY = 5;
  localparam int N_RANDOM = 1950;

  typedef struct {
    logic signed [CB-1:0] cx, cy, kx, ky;
    logic [CB-2:0] r, w, h;
    int want;  // -1: use predictor
  } hit_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] in_center_x = '0, in_center_y = '0, in_corner_x = '0, in_corner_y = '0;
  logic [CB-2:0] in_circle_radius = '0, in_rect_width = '0, in_rect_height = '0;
  logic out_valid, out_hit;

  bit hit_queue[$];
  int errors = 0;
  int send_idle_pct = 19;
  hit_req_t dir_rows[$];

  circle_rectangle_hit_test #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_circle_radius(in_circle_radius), .in_corner_x(in_corner_x),
    .in_corner_y(in_corner_y), .in_rect_width(in_rect_width),
    .in_rect_height(in_rect_height), .out_valid(out_valid), .out_hit(out_hit)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // does sqrt(rem) >= u
  function automatic bit root_at_least(longint u, logic [127:0] rem);
    logic [127:0] m;
    if (u <= 0) return 1'b1;
    m = 128'(u);
    return m * m <= rem;
  endfunction

  // does sqrt(rem) <= v
  function automatic bit root_at_most(longint v, logic [127:0] rem);
    logic [127:0] m;
    if (v < 0) return 1'b0;
    m = 128'(v);
    return rem <= m * m;
  endfunction

  // one edge: off across the edge, c center along it, segment a..a+len
  function automatic bit edge_crossed(longint off, longint c, longint a, longint len,
                                      longint r);
    longint d, lo, hi;
    logic [127:0] rem;
    if (len == 0) return 1'b0;
    d = (off < 0) ? -off : off;
    if (d >= r) return 1'b0;
    rem = 128'(r * r - d * d);
    lo = a - c;
    hi = a + len - c;
    if (root_at_least(lo, rem) && root_at_most(hi, rem)) return 1'b1;
    if (root_at_most(-lo, rem) && root_at_least(-hi, rem)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit predict_hit(hit_req_t q);
    longint cx, cy, kx, ky, r, w, h, xl;
    cx = longint'(q.cx); cy = longint'(q.cy); kx = longint'(q.kx); ky = longint'(q.ky);
    r = longint'(q.r); w = longint'(q.w); h = longint'(q.h);
    xl = kx - w;
    return edge_crossed(xl - cx, cy, ky, h, r) || edge_crossed(ky + h - cy, cx, xl, w, r)
        || edge_crossed(ky - cy, cx, xl, w, r);
  endfunction

  function automatic hit_req_t mk(longint cx, longint cy, longint r, longint kx,
                                  longint ky, longint w, longint h, int want);
    hit_req_t q;
    q.cx = CB'(cx); q.cy = CB'(cy); q.r = (CB-1)'(r); q.kx = CB'(kx); q.ky = CB'(ky);
    q.w = (CB-1)'(w); q.h = (CB-1)'(h);
    q.want = want;
    return q;
  endfunction

  // random request; mostly circles placed near a modest rectangle
  function automatic hit_req_t random_req();
    hit_req_t q;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      q.cx = CB'($urandom); q.cy = CB'($urandom); q.kx = CB'($urandom); q.ky = CB'($urandom);
      q.r = (CB-1)'($urandom); q.w = (CB-1)'($urandom); q.h = (CB-1)'($urandom);
    end else begin
      q.kx = CB'($urandom_range(0, 8000) - 4000);
      q.ky = CB'($urandom_range(0, 8000) - 4000);
      q.w = (sel == 2) ? '0 : (CB-1)'($urandom_range(0, 3000));
      q.h = (sel == 3) ? '0 : (CB-1)'($urandom_range(0, 3000));
      q.cx = CB'(q.kx - $signed({1'b0, q.w}) + $urandom_range(0, 8000) - 4000);
      q.cy = CB'(q.ky + $urandom_range(0, 8000) - 4000);
      q.r = (CB-1)'($urandom_range(0, 4000));
      if (sel == 4) q.cx = q.kx - $signed({1'b0, q.w});
      if (sel == 5) q.cy = q.ky;
    end
    q.want = -1;
    return q;
  endfunction

  // drive one request at the falling edge, wait for acceptance
  task automatic send_req(hit_req_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_center_x <= q.cx; in_center_y <= q.cy; in_circle_radius <= q.r;
    in_corner_x <= q.kx; in_corner_y <= q.ky;
    in_rect_width <= q.w; in_rect_height <= q.h;
    @(posedge clk);
    while (busy) @(posedge clk);
    hit_queue.push_back(q.want < 0 ? predict_hit(q) : bit'(q.want));
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (hit_queue.size() == 0) report_mismatch("result with no request pending");
      else begin
        bit exp_hit;
        exp_hit = hit_queue.pop_front();
        if (out_hit !== exp_hit)
          report_mismatch($sformatf("hit got %b want %b", out_hit, exp_hit));
      end
    end
  end

  // stimulus
  initial begin
    hit_req_t q;
    // directed rows: extremes, zero sizes, tangent, center on a line
    dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 100, 0, 200, 200, 0));
    dir_rows.push_back(mk(0, 0, 256, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 100, 1000, 0, 900, 0, 1));
    dir_rows.push_back(mk(0, 0, 100, 1000, 100, 2000, 50, 0));
    dir_rows.push_back(mk(0, 0, 100, 1000, -500, 1100, 1000, 0));
    dir_rows.push_back(mk(0, 0, 100, 1000, 0, 1000, 500, 1));
    dir_rows.push_back(mk(0, 0, 100, 1000, -300, 1000, 300, 1));
    dir_rows.push_back(mk(0, 0, 100, 1000, 50, 1100, 500, -1));
    dir_rows.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607, 8388607, -1));
    dir_rows.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608, 8388607, 8388607, -1));
    dir_rows.push_back(mk(-1, -1, 8388607, -1, -1, 8388607, 8388607, -1));
    dir_rows.push_back(mk(8388607, -8388608, 1, 8388607, -8388608, 0, 8388607, -1));
    dir_rows.push_back(mk(0, 0, 300, 400, 0, 800, 0, -1));
    dir_rows.push_back(mk(0, 0, 500, 0, -300, 400, 100, -1));
    dir_rows.push_back(mk(0, 0, 500, 0, 300, 400, 100, -1));
    dir_rows.push_back(mk(5, 5, 5, 5, 5, 5, 5, -1));
    dir_rows.push_back(mk(0, 0, 8388607, 0, 0, 1, 1, -1));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) send_req(dir_rows[i]);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 52 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        q = random_req();
        send_req(q);
      end
    end
    start <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
